// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each use expands to one labeled
// concurrent assertion on the rising clock edge, disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle assertion failed");

`endif

// ----- src/ttms_pkg.sv -----
package ttms_pkg;

   // Field widths.
   localparam int unsigned TimeWidth   = 16;
   localparam int unsigned DutyWidth   = 8;
   localparam int unsigned DirWidth    = 2;
   localparam int unsigned KindWidth   = 2;
   localparam int unsigned CmdWidth    = 2;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrDataWidth = 16;
   localparam int unsigned ReqDataWidth = 8;
   localparam int unsigned RspDataWidth = 24;

   typedef logic [TimeWidth-1:0] time_type;
   typedef logic [DutyWidth-1:0] duty_type;
   typedef logic [DirWidth-1:0]  dir_type;
   typedef logic [KindWidth-1:0] kind_type;

   // Input beat kinds carried on tuser.
   typedef enum logic [CmdWidth-1:0] {
      CMD_TICK   = 2'd0,
      CMD_START  = 2'd1,
      CMD_SAMPLE = 2'd2
   } cmd_type;

   // H-bridge input codes {in1,in2}.
   localparam dir_type DIR_OFF = 2'd0;
   localparam dir_type DIR_REV = 2'd1;
   localparam dir_type DIR_FWD = 2'd2;

   // Action kinds.
   localparam kind_type ACT_LEFT90  = 2'd0;
   localparam kind_type ACT_RIGHT90 = 2'd1;
   localparam kind_type ACT_ULEFT   = 2'd2;
   localparam kind_type ACT_URIGHT  = 2'd3;

   // Configuration register indexes.
   localparam logic [CsrIdxWidth-1:0] REG_TURN_DURATION  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] REG_PAUSE_DURATION = 3'd1;
   localparam logic [CsrIdxWidth-1:0] REG_SPIN_DUTY      = 3'd2;
   localparam logic [CsrIdxWidth-1:0] REG_STRAIGHT_DUTY  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] REG_STRONG_DUTY    = 3'd4;
   localparam logic [CsrIdxWidth-1:0] REG_LIGHT_DUTY     = 3'd5;

   // Register reset values.
   localparam time_type TURN_DURATION_RESET  = 16'd550;
   localparam time_type PAUSE_DURATION_RESET = 16'd200;
   localparam duty_type SPIN_DUTY_RESET      = 8'd130;
   localparam duty_type STRAIGHT_DUTY_RESET  = 8'd50;
   localparam duty_type STRONG_DUTY_RESET    = 8'd250;
   localparam duty_type LIGHT_DUTY_RESET     = 8'd0;

   localparam time_type TIME_MAX = '1;

   // Step within an action.
   typedef enum logic [3:0] {
      PH_START = 4'b0001,
      PH_SPIN1 = 4'b0010,
      PH_PAUSE = 4'b0100,
      PH_SPIN2 = 4'b1000
   } phase_type;

   // Result item, left_duty in the lowest bits.
   typedef struct packed {
      logic     action_busy;
      dir_type  right_direction;
      dir_type  left_direction;
      duty_type right_duty;
      duty_type left_duty;
   } result_type;

   localparam int unsigned ResultWidth = $bits(result_type);

endpackage

// ----- src/timed_turn_motor_sequencer_core.sv -----
// Channel   | Direction | Ports                   | Contents
// ----------+-----------+-------------------------+--------------------------------
// req       | in        | req_tvalid/tready/tdata | tick, start or line sample
//           |           | req_tuser               | command
// rsp       | out       | rsp_tvalid/tready/tdata | drive and busy after each beat
// csr       | in        | csr_valid/ready         | register write, index and data
//
// One result beat per request beat; with the output register free, rsp_tvalid
// rises in the cycle after acceptance. A request beat is taken in every cycle
// while the skid stage is empty; the single compare-and-update of the action
// timer sets that figure. A two-entry output (register plus skid) keeps taking
// requests while one result waits, and stalls only when both are full.
// Reset is synchronous and active high; the block is idle with motors off after it.
// csr_ready is always high; writes go straight to the registers.
`include "assert_macros.svh"

module timed_turn_motor_sequencer_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [1:0] action_kind, [2] left_on_line, [3] right_on_line, [7:4] zero
   input  logic [ttms_pkg::ReqDataWidth-1:0] req_tdata,
   // [1:0] command
   input  logic [ttms_pkg::CmdWidth-1:0]     req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] left_duty, [15:8] right_duty, [17:16] left_direction,
   // [19:18] right_direction, [20] action_busy, [23:21] zero
   output logic [ttms_pkg::RspDataWidth-1:0] rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ttms_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [ttms_pkg::CsrDataWidth-1:0] csr_data
);
   import ttms_pkg::*;

   // Configuration registers.
   time_type turn_dur_ff;
   time_type pause_dur_ff;
   duty_type spin_duty_ff;
   duty_type straight_duty_ff;
   duty_type strong_duty_ff;
   duty_type light_duty_ff;

   // Sequencer state.
   logic      busy_ff, busy_in;
   kind_type  kind_ff, kind_in;
   phase_type phase_ff, phase_in;
   time_type  elapsed_ff, elapsed_in;
   duty_type  left_duty_ff, left_duty_in;
   duty_type  right_duty_ff, right_duty_in;
   dir_type   left_dir_ff, left_dir_in;
   dir_type   right_dir_ff, right_dir_in;

   // Output register and skid stage.
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff, out_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff, skid_data_in;

   logic       req_fire;
   logic       rsp_fire;
   cmd_type    cmd;
   kind_type   req_kind;
   logic       req_left;
   logic       req_right;
   logic       to_left;
   logic       uturn;
   time_type   elapsed_inc;
   time_type   limit;
   logic       limit_hit;
   result_type result;

   assign csr_ready  = 1'b1;
   assign req_tready = ~skid_valid_ff;
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_fire   = rsp_tvalid & rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth - ResultWidth){1'b0}}, out_data_ff};

   assign cmd       = cmd_type'(req_tuser);
   assign req_kind  = req_tdata[1:0];
   assign req_left  = req_tdata[2];
   assign req_right = req_tdata[3];

   assign to_left     = (kind_ff == ACT_LEFT90) || (kind_ff == ACT_ULEFT);
   assign uturn       = (kind_ff == ACT_ULEFT) || (kind_ff == ACT_URIGHT);
   assign elapsed_inc = (elapsed_ff == TIME_MAX) ? elapsed_ff : elapsed_ff + 16'd1;
   assign limit       = (phase_ff == PH_PAUSE) ? pause_dur_ff : turn_dur_ff;
   assign limit_hit   = elapsed_inc >= limit;

   // Next sequencer state for the beat on the request channel.
   always_comb begin
      busy_in       = busy_ff;
      kind_in       = kind_ff;
      phase_in      = phase_ff;
      elapsed_in    = elapsed_ff;
      left_duty_in  = left_duty_ff;
      right_duty_in = right_duty_ff;
      left_dir_in   = left_dir_ff;
      right_dir_in  = right_dir_ff;

      unique case (cmd)
         CMD_TICK: begin
            if (busy_ff) begin
               if (phase_ff == PH_START) begin
                  left_duty_in  = spin_duty_ff;
                  right_duty_in = spin_duty_ff;
                  left_dir_in   = to_left ? DIR_REV : DIR_FWD;
                  right_dir_in  = to_left ? DIR_FWD : DIR_REV;
                  phase_in      = PH_SPIN1;
                  elapsed_in    = '0;
               end else if (!limit_hit) begin
                  elapsed_in = elapsed_inc;
               end else if (!uturn || phase_ff == PH_SPIN2) begin
                  // Last phase done: stop and go idle.
                  left_duty_in  = '0;
                  right_duty_in = '0;
                  left_dir_in   = DIR_OFF;
                  right_dir_in  = DIR_OFF;
                  busy_in       = 1'b0;
                  phase_in      = PH_START;
                  elapsed_in    = '0;
               end else if (phase_ff == PH_SPIN1) begin
                  left_duty_in  = '0;
                  right_duty_in = '0;
                  left_dir_in   = DIR_OFF;
                  right_dir_in  = DIR_OFF;
                  phase_in      = PH_PAUSE;
                  elapsed_in    = '0;
               end else begin
                  left_duty_in  = spin_duty_ff;
                  right_duty_in = spin_duty_ff;
                  left_dir_in   = to_left ? DIR_REV : DIR_FWD;
                  right_dir_in  = to_left ? DIR_FWD : DIR_REV;
                  phase_in      = PH_SPIN2;
                  elapsed_in    = '0;
               end
            end
         end
         CMD_START: begin
            busy_in    = 1'b1;
            kind_in    = req_kind;
            phase_in   = PH_START;
            elapsed_in = '0;
         end
         CMD_SAMPLE: begin
            left_dir_in  = DIR_FWD;
            right_dir_in = DIR_FWD;
            case ({req_left, req_right})
               2'b00: begin
                  left_duty_in  = straight_duty_ff;
                  right_duty_in = straight_duty_ff;
               end
               2'b10: begin
                  left_duty_in  = light_duty_ff;
                  right_duty_in = strong_duty_ff;
               end
               2'b01: begin
                  left_duty_in  = strong_duty_ff;
                  right_duty_in = light_duty_ff;
               end
               default: begin
                  left_duty_in  = '0;
                  right_duty_in = '0;
                  left_dir_in   = DIR_OFF;
                  right_dir_in  = DIR_OFF;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.left_duty       = left_duty_in;
      result.right_duty      = right_duty_in;
      result.left_direction  = left_dir_in;
      result.right_direction = right_dir_in;
      result.action_busy     = busy_in;
   end

   // The skid stage fills only when a new result arrives while the output
   // register is full and not being drained.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_fire) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_fire) begin
         if (!out_valid_ff || rsp_fire) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (rsp_fire) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_dur_ff      <= TURN_DURATION_RESET;
         pause_dur_ff     <= PAUSE_DURATION_RESET;
         spin_duty_ff     <= SPIN_DUTY_RESET;
         straight_duty_ff <= STRAIGHT_DUTY_RESET;
         strong_duty_ff   <= STRONG_DUTY_RESET;
         light_duty_ff    <= LIGHT_DUTY_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_TURN_DURATION:  turn_dur_ff      <= csr_data;
            REG_PAUSE_DURATION: pause_dur_ff     <= csr_data;
            REG_SPIN_DUTY:      spin_duty_ff     <= csr_data[DutyWidth-1:0];
            REG_STRAIGHT_DUTY:  straight_duty_ff <= csr_data[DutyWidth-1:0];
            REG_STRONG_DUTY:    strong_duty_ff   <= csr_data[DutyWidth-1:0];
            REG_LIGHT_DUTY:     light_duty_ff    <= csr_data[DutyWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         kind_ff       <= ACT_LEFT90;
         phase_ff      <= PH_START;
         elapsed_ff    <= '0;
         left_duty_ff  <= '0;
         right_duty_ff <= '0;
         left_dir_ff   <= DIR_OFF;
         right_dir_ff  <= DIR_OFF;
      end else if (req_fire) begin
         busy_ff       <= busy_in;
         kind_ff       <= kind_in;
         phase_ff      <= phase_in;
         elapsed_ff    <= elapsed_in;
         left_duty_ff  <= left_duty_in;
         right_duty_ff <= right_duty_in;
         left_dir_ff   <= left_dir_in;
         right_dir_ff  <= right_dir_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   `ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `ASSERT_SAME(a_idle_phase_start, clock, reset, !busy_ff, phase_ff == PH_START)
   `ASSERT_SAME(a_fresh_phase_zero, clock, reset, phase_ff == PH_START, elapsed_ff == '0)
   `ASSERT_NEXT(a_idle_tick_stays_idle, clock, reset,
      req_fire && cmd == CMD_TICK && !busy_ff, !busy_ff)

endmodule
